FILE: design/qrs_pkg.sv
// qrs_pkg: shared constants, result codes and control struct for the quadratic root solver
// no dependencies

package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int ROOT_FRAC_DEF  = 16;
  localparam int ROOT_WIDTH     = 32;
  localparam int KIND_WIDTH     = 3;

  localparam logic [KIND_WIDTH-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_INF  = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_LIN  = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_DBL  = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_TWO  = 3'd4;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic                  neg1;
    logic                  neg2;
  } ctl_t;

endpackage

FILE: design/qrs_if.sv
// qrs_coef_if / qrs_root_if: valid-ready request channels for coefficients and roots
// depends on qrs_pkg

interface qrs_coef_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
  logic                                      valid;
  logic                                      ready;
  logic        [qrs_pkg::KIND_WIDTH-1:0]     root_kind;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_first;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]     root_second;
  logic                                      saturated;

  modport source (output valid, root_kind, root_first, root_second, saturated, input ready);
  modport sink (input valid, root_kind, root_first, root_second, saturated, output ready);
endinterface

FILE: design/qrs_sqrt_cell.sv
// qrs_sqrt_cell: one digit step of a pipelined floored square root, with pass-through payload
// depends on qrs_pkg

module qrs_sqrt_cell #(
  parameter int SW     = 17,
  parameter int SIDE_W = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  qrs_pkg::ctl_t         up_ctl,
  input  logic [SW:0]           up_rem,
  input  logic [SW-1:0]         up_root,
  input  logic [2*SW-1:0]       up_rad,
  input  logic [SIDE_W-1:0]     up_side,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output qrs_pkg::ctl_t         dn_ctl,
  output logic [SW:0]           dn_rem,
  output logic [SW-1:0]         dn_root,
  output logic [2*SW-1:0]       dn_rad,
  output logic [SIDE_W-1:0]     dn_side
);

  logic [SW+2:0] rem_sh;
  logic [SW+2:0] trial;
  logic          ge;
  logic [SW+2:0] rem_diff;

  assign rem_sh   = {up_rem, up_rad[2*SW-1 -: 2]};
  assign trial    = {1'b0, up_root, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_diff = ge ? rem_sh - trial : rem_sh;
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_ctl  <= up_ctl;
      dn_rem  <= rem_diff[SW:0];
      dn_root <= {up_root[SW-2:0], ge};
      dn_rad  <= {up_rad[2*SW-3:0], 2'b00};
      dn_side <= up_side;
    end
  end

endmodule

FILE: design/qrs_div_cell.sv
// qrs_div_cell: one restoring quotient bit for two dividends sharing one divisor
// depends on qrs_pkg

module qrs_div_cell #(
  parameter int QW = 34,
  parameter int DW = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  qrs_pkg::ctl_t      up_ctl,
  input  logic [DW-1:0]      up_den,
  input  logic [1:0][DW-1:0] up_rem,
  input  logic [1:0][QW-1:0] up_x,
  output logic               dn_valid,
  input  logic               dn_ready,
  output qrs_pkg::ctl_t      dn_ctl,
  output logic [DW-1:0]      dn_den,
  output logic [1:0][DW-1:0] dn_rem,
  output logic [1:0][QW-1:0] dn_x
);

  logic [1:0][DW:0]   sh;
  logic [1:0]         ge;
  logic [1:0][DW:0]   diff;
  logic [1:0][QW-1:0] x_new;

  // dividend and quotient share one shifting register per lane; the remainder has its own
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sh[i]    = {up_rem[i], up_x[i][QW-1]};
      ge[i]    = sh[i] >= {1'b0, up_den};
      diff[i]  = ge[i] ? sh[i] - {1'b0, up_den} : sh[i];
      x_new[i] = {up_x[i][QW-2:0], ge[i]};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_ctl    <= up_ctl;
      dn_den    <= up_den;
      dn_rem[0] <= diff[0][DW-1:0];
      dn_rem[1] <= diff[1][DW-1:0];
      dn_x      <= x_new;
    end
  end

endmodule

FILE: design/quadratic_root_solver.sv
// quadratic_root_solver: one request per cycle unless a stalled output backs up the pipeline, set
// by the cell chains advancing one digit a stage. stages: products, classify, COEF_WIDTH+1 square
// root cells, setup, COEF_WIDTH+2+ROOT_FRAC_BITS divide cells, saturation and output register.
// a stalled output holds; any bubble still in the chain is filled from the input. synchronous
// reset clears all valid flags only.
// depends on qrs_pkg, qrs_if, qrs_sqrt_cell, qrs_div_cell

module quadratic_root_solver #(
  parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_DEF
) (
  input logic         clk,
  input logic         rst,
  qrs_coef_if.sink    coefs,
  qrs_root_if.source  roots
);

  localparam int W    = COEF_WIDTH;
  localparam int SW   = W + 1;               // square root digits
  localparam int NSW  = W + 3;               // signed numerator width
  localparam int NMW  = W + 2;               // numerator magnitude width
  localparam int DW   = W + 1;               // divisor magnitude width
  localparam int QW   = NMW + ROOT_FRAC_BITS; // quotient bits, one per divide cell
  localparam int EW   = (QW + 1 > 33) ? QW + 1 : 33;
  localparam int RW   = qrs_pkg::ROOT_WIDTH;
  localparam int SIDE = 3 * W;
  localparam logic [EW-1:0] LIM_POS = EW'(64'h7FFF_FFFF);
  localparam logic [EW-1:0] LIM_NEG = EW'(64'h8000_0000);

  // ---------------- stage 1: magnitudes and products
  logic                v1;
  logic                ready1;
  logic signed [W-1:0] a1, b1, c1;
  logic [2*W-1:0]      bb1, ac1;
  logic [W-1:0]        ma, mb, mc;
  logic                ready2;

  assign ma = coefs.coef_a[W-1] ? W'(-coefs.coef_a) : coefs.coef_a;
  assign mb = coefs.coef_b[W-1] ? W'(-coefs.coef_b) : coefs.coef_b;
  assign mc = coefs.coef_c[W-1] ? W'(-coefs.coef_c) : coefs.coef_c;
  assign ready1 = !v1 || ready2;
  assign coefs.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= coefs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      a1  <= coefs.coef_a;
      b1  <= coefs.coef_b;
      c1  <= coefs.coef_c;
      bb1 <= mb * mb;
      ac1 <= ma * mc;
    end
  end

  // ---------------- stage 2: exact discriminant and case
  logic                v2;
  qrs_pkg::ctl_t       ctl2;
  logic [2*SW-1:0]     rad2;
  logic [SIDE-1:0]     side2;
  logic                ac_pos;
  logic [2*W+2:0]      dsum;
  logic [qrs_pkg::KIND_WIDTH-1:0] kind_calc;
  logic                sq_ready0;

  assign ac_pos = (a1[W-1] == c1[W-1]) && (c1 != '0);
  assign dsum   = ac_pos ? {3'b000, bb1} - {1'b0, ac1, 2'b00}
                         : {3'b000, bb1} + {1'b0, ac1, 2'b00};

  always_comb begin
    if (a1 == '0) begin
      if (b1 == '0) begin
        kind_calc = (c1 == '0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
      end else begin
        kind_calc = qrs_pkg::KIND_LIN;
      end
    end else if (dsum[2*W+2]) begin
      kind_calc = qrs_pkg::KIND_NONE;   // negative discriminant
    end else if (dsum == '0) begin
      kind_calc = qrs_pkg::KIND_DBL;
    end else begin
      kind_calc = qrs_pkg::KIND_TWO;
    end
  end

  assign ready2 = !v2 || sq_ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      ctl2  <= '{kind: kind_calc, neg1: 1'b0, neg2: 1'b0};
      rad2  <= dsum[2*W+1:0];
      side2 <= {a1, b1, c1};
    end
  end

  // ---------------- square root chain, one result bit per cell
  logic [SW:0]         sq_v;
  logic [SW:0]         sq_r;
  qrs_pkg::ctl_t       sq_ctl  [SW+1];
  logic [SW:0]         sq_rem  [SW+1];
  logic [SW-1:0]       sq_root [SW+1];
  logic [2*SW-1:0]     sq_rad  [SW+1];
  logic [SIDE-1:0]     sq_side [SW+1];
  logic                ready3;

  assign sq_v[0]    = v2;
  assign sq_ctl[0]  = ctl2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = rad2;
  assign sq_side[0] = side2;
  assign sq_ready0  = sq_r[0];
  assign sq_r[SW]   = ready3;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .SIDE_W(SIDE)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (sq_v[k]),
      .up_ready (sq_r[k]),
      .up_ctl   (sq_ctl[k]),
      .up_rem   (sq_rem[k]),
      .up_root  (sq_root[k]),
      .up_rad   (sq_rad[k]),
      .up_side  (sq_side[k]),
      .dn_valid (sq_v[k+1]),
      .dn_ready (sq_r[k+1]),
      .dn_ctl   (sq_ctl[k+1]),
      .dn_rem   (sq_rem[k+1]),
      .dn_root  (sq_root[k+1]),
      .dn_rad   (sq_rad[k+1]),
      .dn_side  (sq_side[k+1])
    );
  end

  // ---------------- stage 3: numerators, divisor and quotient signs
  logic                  v3;
  qrs_pkg::ctl_t         ctl3;
  logic [DW-1:0]         den3;
  logic [1:0][QW-1:0]    x3;
  logic signed [W-1:0]   a3, b3, c3;
  logic signed [NSW-1:0] bx, cx, sx, n1, n2, n1m, n2m;
  logic signed [DW-1:0]  den, denm;
  logic                  dv_ready0;

  assign a3 = sq_side[SW][3*W-1 -: W];
  assign b3 = sq_side[SW][2*W-1 -: W];
  assign c3 = sq_side[SW][W-1:0];
  assign bx = NSW'(b3);
  assign cx = NSW'(c3);
  assign sx = NSW'(sq_root[SW]);

  always_comb begin
    n1  = '0;
    n2  = '0;
    den = {a3, 1'b0};
    case (sq_ctl[SW].kind)
      qrs_pkg::KIND_LIN: begin
        n1  = -cx;
        den = DW'(b3);
      end
      qrs_pkg::KIND_DBL: begin
        n1 = -bx;
        n2 = -bx;
      end
      qrs_pkg::KIND_TWO: begin
        n1 = sx - bx;
        n2 = -bx - sx;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    n1m  = n1[NSW-1] ? -n1 : n1;
    n2m  = n2[NSW-1] ? -n2 : n2;
    denm = den[DW-1] ? -den : den;
  end

  assign ready3 = !v3 || dv_ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      ctl3.kind <= sq_ctl[SW].kind;
      ctl3.neg1 <= n1[NSW-1] ^ den[DW-1];
      ctl3.neg2 <= n2[NSW-1] ^ den[DW-1];
      den3      <= denm;
      x3[0]     <= {n1m[NMW-1:0], {ROOT_FRAC_BITS{1'b0}}};
      x3[1]     <= {n2m[NMW-1:0], {ROOT_FRAC_BITS{1'b0}}};
    end
  end

  // ---------------- divide chain, one quotient bit per cell
  logic [QW:0]        dv_v;
  logic [QW:0]        dv_r;
  qrs_pkg::ctl_t      dv_ctl [QW+1];
  logic [DW-1:0]      dv_den [QW+1];
  logic [1:0][DW-1:0] dv_rem [QW+1];
  logic [1:0][QW-1:0] dv_x   [QW+1];
  logic               ready4;

  assign dv_v[0]   = v3;
  assign dv_ctl[0] = ctl3;
  assign dv_den[0] = den3;
  assign dv_rem[0] = '0;
  assign dv_x[0]   = x3;
  assign dv_ready0 = dv_r[0];
  assign dv_r[QW]  = ready4;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell #(.QW(QW), .DW(DW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv_v[k]),
      .up_ready (dv_r[k]),
      .up_ctl   (dv_ctl[k]),
      .up_den   (dv_den[k]),
      .up_rem   (dv_rem[k]),
      .up_x     (dv_x[k]),
      .dn_valid (dv_v[k+1]),
      .dn_ready (dv_r[k+1]),
      .dn_ctl   (dv_ctl[k+1]),
      .dn_den   (dv_den[k+1]),
      .dn_rem   (dv_rem[k+1]),
      .dn_x     (dv_x[k+1])
    );
  end

  // ---------------- stage 4: clamp to 32 bits and output register
  logic [1:0][EW-1:0] qe;
  logic [1:0]         over;
  logic [1:0][RW-1:0] res;
  logic [1:0]         negq;
  logic [RW-1:0]      r1_calc, r2_calc;
  logic               sat_calc;
  logic               v4;

  assign negq = {dv_ctl[QW].neg2, dv_ctl[QW].neg1};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qe[i] = EW'(dv_x[QW][i]);
      if (negq[i]) begin
        over[i] = qe[i] > LIM_NEG;
        res[i]  = over[i] ? LIM_NEG[RW-1:0] : RW'(-qe[i][RW-1:0]);
      end else begin
        over[i] = qe[i] > LIM_POS;
        res[i]  = over[i] ? LIM_POS[RW-1:0] : qe[i][RW-1:0];
      end
    end
    r1_calc  = '0;
    r2_calc  = '0;
    sat_calc = 1'b0;
    case (dv_ctl[QW].kind)
      qrs_pkg::KIND_LIN: begin
        r1_calc  = res[0];
        sat_calc = over[0];
      end
      qrs_pkg::KIND_DBL: begin
        r1_calc  = res[0];
        r2_calc  = res[0];
        sat_calc = over[0];
      end
      qrs_pkg::KIND_TWO: begin
        r1_calc  = res[0];
        r2_calc  = res[1];
        sat_calc = over[0] | over[1];
      end
      default: begin
        sat_calc = 1'b0;
      end
    endcase
  end

  assign ready4 = !v4 || roots.ready;
  assign roots.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      roots.root_kind   <= dv_ctl[QW].kind;
      roots.root_first  <= r1_calc;
      roots.root_second <= r2_calc;
      roots.saturated   <= sat_calc;
    end
  end

endmodule
